FILE: design/msfc_pkg.sv
// Package: shared constants, types and codes for the Mode S frame CRC checker.
package msfc_pkg;

  localparam int FRAME_BYTES = 14;
  localparam int POS_W       = 4;
  localparam int CRC_W       = 24;
  localparam int BYTE_W      = 8;
  localparam int DF_W        = 5;

  localparam logic [CRC_W-1:0] CRC_GEN = 24'hFFF409;

  localparam logic [POS_W-1:0] POS_FRAME_END   = POS_W'(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_PARITY_0    = POS_W'(FRAME_BYTES - 3);
  localparam logic [POS_W-1:0] POS_PARITY_1    = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_PARITY_2    = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_FORMAT      = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ADDR_0      = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ADDR_1      = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ADDR_2      = POS_W'(3);

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_MISMATCH   = 2'd1,
    STATUS_BAD_LENGTH = 2'd2
  } status_t;

endpackage

FILE: design/msfc_if.sv
// Interfaces: byte input channel and frame result channel.
interface msfc_in_if;
  logic                        valid;
  logic                        ready;
  logic [msfc_pkg::BYTE_W-1:0] frame_byte;
  logic                        last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface msfc_out_if;
  logic                       valid;
  logic                       ready;
  msfc_pkg::status_t          status;
  logic [msfc_pkg::DF_W-1:0]  downlink_format;
  logic [msfc_pkg::CRC_W-1:0] aircraft_address;
  logic [msfc_pkg::CRC_W-1:0] received_parity;

  modport source (output valid, status, downlink_format, aircraft_address, received_parity,
                  input ready);
  modport sink   (input valid, status, downlink_format, aircraft_address, received_parity,
                  output ready);
endinterface

FILE: design/msfc_crc_byte.sv
// Byte-wide CRC-24 update, MSB first, generator 0xFFF409.
module msfc_crc_byte (
  input  logic [msfc_pkg::CRC_W-1:0]  crc_in,
  input  logic [msfc_pkg::BYTE_W-1:0] data_in,
  output logic [msfc_pkg::CRC_W-1:0]  crc_out
);

  always_comb begin
    logic [msfc_pkg::CRC_W-1:0] c;
    c = crc_in ^ {data_in, {(msfc_pkg::CRC_W - msfc_pkg::BYTE_W){1'b0}}};
    for (int i = 0; i < msfc_pkg::BYTE_W; i++) begin
      if (c[msfc_pkg::CRC_W-1]) begin
        c = {c[msfc_pkg::CRC_W-2:0], 1'b0} ^ msfc_pkg::CRC_GEN;
      end else begin
        c = {c[msfc_pkg::CRC_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

FILE: design/mode_s_frame_crc_checker.sv
// Top level: Mode S long-frame CRC-24 parity checker.
// Result: registered; appears on out_ch in the cycle after the beat that carries last_byte.
// Throughput: one byte beat per cycle; in_ch stalls only while a result waits unread.
// The byte CRC update is a single combinational stage between frame state and result register.
// Reset: synchronous, active low; clears frame state and the result valid.
module mode_s_frame_crc_checker (
  input  logic         clk,
  input  logic         rst_n,
  msfc_in_if.sink      in_ch,
  msfc_out_if.source   out_ch
);

  logic [msfc_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [msfc_pkg::CRC_W-1:0]  crc_r, crc_nxt;
  logic [msfc_pkg::DF_W-1:0]   fmt_r, fmt_nxt;
  logic [msfc_pkg::CRC_W-1:0]  addr_r, addr_nxt;
  logic [msfc_pkg::CRC_W-1:0]  par_r, par_nxt;
  logic                        ovl_r, ovl_nxt;

  logic                        out_valid_r, out_valid_nxt;
  msfc_pkg::status_t           status_r, status_nxt;
  logic [msfc_pkg::DF_W-1:0]   res_fmt_r, res_fmt_nxt;
  logic [msfc_pkg::CRC_W-1:0]  res_addr_r, res_addr_nxt;
  logic [msfc_pkg::CRC_W-1:0]  res_par_r, res_par_nxt;

  logic [msfc_pkg::CRC_W-1:0]  crc_upd;
  logic                        in_acc;

  msfc_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (in_ch.frame_byte),
    .crc_out (crc_upd)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [msfc_pkg::POS_W-1:0] p;
    logic [msfc_pkg::CRC_W-1:0] c;
    logic [msfc_pkg::DF_W-1:0]  f;
    logic [msfc_pkg::CRC_W-1:0] a;
    logic [msfc_pkg::CRC_W-1:0] q;
    logic                       o;
    logic [msfc_pkg::BYTE_W-1:0] b;

    b = in_ch.frame_byte;
    p = pos_r;
    c = crc_r;
    f = fmt_r;
    a = addr_r;
    q = par_r;
    o = ovl_r;

    if (pos_r < msfc_pkg::POS_FRAME_END) begin
      if (pos_r == msfc_pkg::POS_FORMAT) f = b[msfc_pkg::BYTE_W-1 -: msfc_pkg::DF_W];
      if (pos_r == msfc_pkg::POS_ADDR_0) a[23:16] = b;
      if (pos_r == msfc_pkg::POS_ADDR_1) a[15:8]  = b;
      if (pos_r == msfc_pkg::POS_ADDR_2) a[7:0]   = b;
      if (pos_r < msfc_pkg::POS_PARITY_0) begin
        c = crc_upd;
      end else begin
        if (pos_r == msfc_pkg::POS_PARITY_0) q[23:16] = b;
        if (pos_r == msfc_pkg::POS_PARITY_1) q[15:8]  = b;
        if (pos_r == msfc_pkg::POS_PARITY_2) q[7:0]   = b;
      end
      p = pos_r + 1'b1;
    end else begin
      o = 1'b1;
    end

    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    fmt_nxt       = fmt_r;
    addr_nxt      = addr_r;
    par_nxt       = par_r;
    ovl_nxt       = ovl_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    res_fmt_nxt   = res_fmt_r;
    res_addr_nxt  = res_addr_r;
    res_par_nxt   = res_par_r;

    if (in_acc) begin
      if (in_ch.last_byte) begin
        if (o || (p != msfc_pkg::POS_FRAME_END)) begin
          status_nxt = msfc_pkg::STATUS_BAD_LENGTH;
        end else if (c == q) begin
          status_nxt = msfc_pkg::STATUS_OK;
        end else begin
          status_nxt = msfc_pkg::STATUS_MISMATCH;
        end
        out_valid_nxt = 1'b1;
        res_fmt_nxt   = f;
        res_addr_nxt  = a;
        res_par_nxt   = q;
        pos_nxt       = '0;
        crc_nxt       = '0;
        fmt_nxt       = '0;
        addr_nxt      = '0;
        par_nxt       = '0;
        ovl_nxt       = 1'b0;
      end else begin
        pos_nxt  = p;
        crc_nxt  = c;
        fmt_nxt  = f;
        addr_nxt = a;
        par_nxt  = q;
        ovl_nxt  = o;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= '0;
      fmt_r       <= '0;
      addr_r      <= '0;
      par_r       <= '0;
      ovl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      fmt_r       <= fmt_nxt;
      addr_r      <= addr_nxt;
      par_r       <= par_nxt;
      ovl_r       <= ovl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    res_fmt_r  <= res_fmt_nxt;
    res_addr_r <= res_addr_nxt;
    res_par_r  <= res_par_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.downlink_format  = res_fmt_r;
  assign out_ch.aircraft_address = res_addr_r;
  assign out_ch.received_parity  = res_par_r;

endmodule

FILE: design/msfc_checker.sv
// Checker: port-level assertions for the Mode S frame CRC checker, bound to the top level.
module msfc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [msfc_pkg::CRC_W-1:0] out_parity
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> out_valid)
    else $error("last beat accepted but no result followed");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !($past(out_valid) && !$past(out_ready)) |-> $past(in_acc && in_last))
    else $error("new result without an accepted last beat");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == msfc_pkg::STATUS_OK ||
                   out_status == msfc_pkg::STATUS_MISMATCH ||
                   out_status == msfc_pkg::STATUS_BAD_LENGTH))
    else $error("result status outside defined codes");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_parity))
    else $error("stalled result changed");

endmodule

bind mode_s_frame_crc_checker msfc_checker u_msfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last_byte),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_parity (out_ch.received_parity)
);
